// File: hdl/parid_pkg.sv
`default_nettype none

package parid_pkg;

   // Action codes of an input word.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   // Status codes of a result word.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_POS = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [7:0]         fill_count;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hdl/positional_array_insert_delete_unit.sv
`default_nettype none

// Positional array store. The block holds a dense ordered array of up to DEPTH
// words of DATA_WIDTH bits in one synchronous memory, plus a count of filled
// entries. Each request word asks to insert, delete, update or read at a
// position, and each one yields exactly one response word carrying a status, the
// entry read (zero unless a read succeeds) and the fill count after the action.
// Requests are handled one at a time. An error, an update, an append (insert
// at the fill count) and a delete of the last entry go straight to the post
// state; a read first passes the read state; an insert at position p moves
// each entry from the last one down to p one place up, then writes the new word
// at p; a delete at p moves each entry above p one place down. The shift moves
// one entry per cycle, which is what the memory's single write port allows. The
// next request is taken in the cycle after the response is loaded, even while
// that response is still stalled. Entries hold the low DATA_WIDTH bits of the
// written value and read back zero-extended to 32 bits. Reset empties the store;
// memory contents are not cleared, since no entry at or above the fill count can
// be read.
module positional_array_insert_delete_unit #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  parid_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output parid_pkg::rsp_word_type rsp_data
);

   import parid_pkg::*;

   // Address, count and compare widths.
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_LAST  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_POST  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            act_ff, act_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [31:0]           res_value_ff, res_value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   // Entry memory: one write and one registered read per cycle.
   logic [DATA_WIDTH-1:0] entry_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;

   logic [CMPW-1:0]       pos_cmp;
   logic [CMPW-1:0]       cnt_cmp;
   logic [CMPW-1:0]       pos_plus1;
   logic [CW-1:0]         cnt_minus1;
   logic [DATA_WIDTH-1:0] req_word;
   logic [DATA_WIDTH+31:0] req_word_ext;
   logic [DATA_WIDTH+31:0] rd_data_ext;
   logic [CW+7:0]         cnt_ext;
   logic                  out_free;

   assign pos_cmp      = CMPW'(req_data.position);
   assign cnt_cmp      = CMPW'(count_ff);
   assign pos_plus1    = pos_cmp + CMPW'(1);
   assign cnt_minus1   = count_ff - CW'(1);
   assign req_word_ext = {{DATA_WIDTH{1'b0}}, req_data.value};
   assign req_word     = req_word_ext[DATA_WIDTH-1:0];
   assign rd_data_ext  = {32'd0, rd_data_ff};
   assign cnt_ext      = {8'd0, count_ff};
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      act_in        = act_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = val_ff;
      mem_raddr     = cur_ff;

      // A waiting response leaves once the far side takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in        = req_data.action;
               pos_in        = pos_cmp[AW-1:0];
               val_in        = req_word;
               res_status_in = STAT_OK;
               res_value_in  = '0;
               state_in      = ST_POST;
               case (req_data.action)
                  ACT_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = STAT_FULL;
                     end else if (pos_cmp > cnt_cmp) begin
                        res_status_in = STAT_BAD_POS;
                     end else if (pos_cmp == cnt_cmp) begin
                        // Append: no entries move.
                        mem_we    = 1'b1;
                        mem_waddr = pos_cmp[AW-1:0];
                        mem_wdata = req_word;
                        count_in  = count_ff + CW'(1);
                     end else begin
                        // Start moving from the last filled entry downward.
                        mem_raddr = cnt_minus1[AW-1:0];
                        cur_in    = cnt_minus1[AW-1:0];
                        state_in  = ST_SHIFT;
                     end
                  end
                  ACT_DELETE: begin
                     if (pos_cmp >= cnt_cmp) begin
                        res_status_in = STAT_BAD_POS;
                     end else if (pos_plus1 == cnt_cmp) begin
                        // Removing the last entry moves nothing.
                        count_in = cnt_minus1;
                     end else begin
                        mem_raddr = pos_plus1[AW-1:0];
                        cur_in    = pos_plus1[AW-1:0];
                        state_in  = ST_SHIFT;
                     end
                  end
                  ACT_UPDATE: begin
                     if (pos_cmp >= cnt_cmp) begin
                        res_status_in = STAT_BAD_POS;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_cmp[AW-1:0];
                        mem_wdata = req_word;
                     end
                  end
                  default: begin
                     if (pos_cmp >= cnt_cmp) begin
                        res_status_in = STAT_BAD_POS;
                     end else begin
                        mem_raddr = pos_cmp[AW-1:0];
                        state_in  = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // The entry read last cycle (at cur) is written one place over,
            // while the next one is read; the two addresses never meet.
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            if (act_ff == ACT_INSERT) begin
               mem_waddr = cur_ff + AW'(1);
               if (cur_ff == pos_ff) begin
                  state_in = ST_LAST;
               end else begin
                  mem_raddr = cur_ff - AW'(1);
                  cur_in    = cur_ff - AW'(1);
               end
            end else begin
               mem_waddr = cur_ff - AW'(1);
               if (CW'(cur_ff) == cnt_minus1) begin
                  count_in = cnt_minus1;
                  state_in = ST_POST;
               end else begin
                  mem_raddr = cur_ff + AW'(1);
                  cur_in    = cur_ff + AW'(1);
               end
            end
         end
         ST_LAST: begin
            // The hole at the insert position now takes the new word.
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            state_in  = ST_POST;
         end
         ST_READ: begin
            res_value_in = rd_data_ext[31:0];
            state_in     = ST_POST;
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = res_status_ff;
               rsp_data_in.read_value = res_value_ff;
               rsp_data_in.fill_count = cnt_ext[7:0];
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   // The memory is written while idle only by the word being accepted.
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ST_IDLE) |-> req_valid)
      else $error("memory write while idle without a request");

   // A new response appears only out of the post state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_POST)
      else $error("response raised outside the post state");

   // The count moves only on the cycles that finish an insert or a delete.
   a_count_move: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == ST_IDLE ||
                              $past(state_ff) == ST_SHIFT ||
                              $past(state_ff) == ST_LAST))
      else $error("fill count changed in a wrong state");

endmodule

`default_nettype wire
